FILE: rtl/zchr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed text decoder package
// Shared types, codes and the per-code decode function of the Z-character
// text decoder.
// ----------------------------------------------------------------------------
package zchr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Decoder shift state.
    typedef enum logic [2:0] {
        MODE_A0,
        MODE_A1,
        MODE_A2,
        MODE_AB1,
        MODE_AB2,
        MODE_AB3,
        MODE_ESC1,
        MODE_ESC2
    } t_mode;

    // Result kind as carried on tuser.
    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_ABBREV = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    // Special codes.
    localparam logic [4:0] CODE_ABBR1  = 5'd1;
    localparam logic [4:0] CODE_ABBR2  = 5'd2;
    localparam logic [4:0] CODE_ABBR3  = 5'd3;
    localparam logic [4:0] CODE_SHIFT1 = 5'd4;
    localparam logic [4:0] CODE_SHIFT2 = 5'd5;
    localparam logic [4:0] CODE_ESCAPE = 5'd6;

    // Per-word step counter values.
    localparam logic [1:0] STEP_CODE0 = 2'd0;
    localparam logic [1:0] STEP_CODE1 = 2'd1;
    localparam logic [1:0] STEP_CODE2 = 2'd2;
    localparam logic [1:0] STEP_END   = 2'd3;

    // One queued word, already split into its three codes.
    typedef struct packed {
        logic       last;
        logic [4:0] c0;
        logic [4:0] c1;
        logic [4:0] c2;
    } t_entry;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // Outcome of running one code through the shift state.
    typedef struct packed {
        t_mode      mode;
        logic [4:0] esc;
        logic       emit;
        t_kind      kind;
        logic [7:0] ch;
        logic [6:0] ab;
    } t_step;

    function automatic logic [7:0] alpha_char(input t_mode m, input logic [4:0] code);
        logic [7:0] c;
        logic [7:0] r;
        c = {3'b000, code};
        r = 8'h20;
        case (m)
            MODE_A1: begin
                if (code >= 5'd6) r = c + 8'h3B;
            end
            MODE_A2: begin
                case (code)
                    5'd7:  r = 8'h0A;
                    5'd18: r = 8'h2E;
                    5'd19: r = 8'h2C;
                    5'd20: r = 8'h21;
                    5'd21: r = 8'h3F;
                    5'd22: r = 8'h5F;
                    5'd23: r = 8'h23;
                    5'd24: r = 8'h27;
                    5'd25: r = 8'h22;
                    5'd26: r = 8'h2F;
                    5'd27: r = 8'h5C;
                    5'd28: r = 8'h2D;
                    5'd29: r = 8'h3A;
                    5'd30: r = 8'h28;
                    5'd31: r = 8'h29;
                    default: begin
                        // Digits sit at codes eight to seventeen.
                        if (code >= 5'd8) r = c + 8'h28;
                    end
                endcase
            end
            default: begin
                if (code >= 5'd6) r = c + 8'h5B;
            end
        endcase
        return r;
    endfunction

    function automatic t_step run_code(input t_mode m, input logic [4:0] esc,
                                       input logic [4:0] code);
        t_step s;
        s.mode = MODE_A0;
        s.esc  = esc;
        s.emit = 1'b0;
        s.kind = KIND_CHAR;
        s.ch   = 8'h00;
        s.ab   = 7'h00;
        case (m)
            MODE_AB1, MODE_AB2, MODE_AB3: begin
                s.emit = 1'b1;
                s.kind = KIND_ABBREV;
                s.ab   = {(m == MODE_AB3) ? 2'd2 : ((m == MODE_AB2) ? 2'd1 : 2'd0), code};
            end
            MODE_ESC1: begin
                s.esc  = code;
                s.mode = MODE_ESC2;
            end
            MODE_ESC2: begin
                // Only the low eight bits of the ten-bit escape survive.
                s.emit = 1'b1;
                s.ch   = {esc[2:0], code};
            end
            default: begin
                case (code)
                    CODE_ABBR1:  s.mode = MODE_AB1;
                    CODE_ABBR2:  s.mode = MODE_AB2;
                    CODE_ABBR3:  s.mode = MODE_AB3;
                    CODE_SHIFT1: s.mode = MODE_A1;
                    CODE_SHIFT2: s.mode = MODE_A2;
                    CODE_ESCAPE: begin
                        if (m == MODE_A2) begin
                            s.mode = MODE_ESC1;
                        end else begin
                            s.emit = 1'b1;
                            s.ch   = alpha_char(m, code);
                        end
                    end
                    default: begin
                        s.emit = 1'b1;
                        s.ch   = alpha_char(m, code);
                    end
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/packed_text_zchar_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed text Z-character decoder
// Decodes 16-bit packed text words into characters, abbreviation indexes and
// end-of-string markers.
//
//   Channel  Dir  tdata                                   tuser  tlast
//   s_axis   in   [15:0] packed_word                      -      -
//   m_axis   out  [7:0] char_code, [14:8] abbrev_index    kind   last_of_word
//
// The back end works through each word one code per step, with a further
// step for the end marker of a last word.
// A four-entry queue lets the input take words while the back end is busy.
// Results appear from an output register in the cycle after their code step.
// Reset is synchronous and active low; it empties the queue and returns the
// shift state to alphabet zero.
// ----------------------------------------------------------------------------
module packed_text_zchar_decoder import zchr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] packed_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_code, [14:8] abbrev_index, [15] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_of_word
);

    t_head head;
    logic  pop;

    zchr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_pop         (pop),
        .o_head        (head)
    );

    zchr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/zchr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed text decoder front end
// Accepts packed words, splits them into their codes and end flag, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module zchr_front import zchr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] packed_word
    input  logic        i_pop,
    output t_head       o_head
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                push;
    t_entry              in_entry;

    assign s_axis_tready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_entry.last = s_axis_tdata[15];
        in_entry.c0   = s_axis_tdata[14:10];
        in_entry.c1   = s_axis_tdata[9:5];
        in_entry.c2   = s_axis_tdata[4:0];
    end

    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != QCNT_W'(QUEUE_DEPTH)) |->
            (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

FILE: rtl/zchr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed text decoder back end
// Runs the queued codes through the shift state one per cycle, holding while
// the output register's result is not taken, and drives the result stream from it.
// ----------------------------------------------------------------------------
module zchr_back import zchr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_code, [14:8] abbrev_index
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_of_word
);

    t_mode       r_mode, n_mode;
    logic [4:0]  r_esc, n_esc;
    logic [1:0]  r_step, n_step;
    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind, n_out_kind;
    logic [7:0]  r_out_ch, n_out_ch;
    logic [6:0]  r_out_ab, n_out_ab;
    logic        r_out_last, n_out_last;

    logic        out_free;
    logic        go;
    logic        end_step;
    logic        done;
    logic        later;
    logic [4:0]  code;
    t_step       cur, la1, la2, la_c2;

    assign out_free = !r_out_valid || m_axis_tready;
    assign go       = i_head.valid && out_free;
    assign end_step = (r_step == STEP_END);
    assign done     = end_step || (r_step == STEP_CODE2 && !i_head.entry.last);
    assign o_pop    = go && done;

    always_comb begin
        case (r_step)
            STEP_CODE0: code = i_head.entry.c0;
            STEP_CODE1: code = i_head.entry.c1;
            default:    code = i_head.entry.c2;
        endcase
    end

    // Look ahead over the remaining codes of the word to tell whether this
    // result is the final one that the word causes.
    always_comb begin
        cur   = run_code(r_mode, r_esc, code);
        la1   = run_code(cur.mode, cur.esc, i_head.entry.c1);
        la2   = run_code(la1.mode, la1.esc, i_head.entry.c2);
        la_c2 = run_code(cur.mode, cur.esc, i_head.entry.c2);
        later = i_head.entry.last
             || (r_step == STEP_CODE0 && (la1.emit || la2.emit))
             || (r_step == STEP_CODE1 && la_c2.emit);
    end

    always_comb begin
        n_mode      = r_mode;
        n_esc       = r_esc;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_ch    = r_out_ch;
        n_out_ab    = r_out_ab;
        n_out_last  = r_out_last;
        if (out_free) begin
            n_out_valid = 1'b0;
        end
        if (go) begin
            n_step = done ? STEP_CODE0 : r_step + 2'd1;
            if (end_step) begin
                n_mode      = MODE_A0;
                n_esc       = 5'd0;
                n_out_valid = 1'b1;
                n_out_kind  = KIND_END;
                n_out_ch    = 8'h00;
                n_out_ab    = 7'h00;
                n_out_last  = 1'b1;
            end else begin
                n_mode = cur.mode;
                n_esc  = cur.esc;
                if (cur.emit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = cur.kind;
                    n_out_ch    = cur.ch;
                    n_out_ab    = cur.ab;
                    n_out_last  = !later;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_ch   <= n_out_ch;
        r_out_ab   <= n_out_ab;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_A0;
            r_esc       <= 5'd0;
            r_step      <= STEP_CODE0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_esc       <= n_esc;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_ab, r_out_ch};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    a_end_step_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_END) |-> (i_head.valid && i_head.entry.last))
        else $error("end step without a pending end word");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_END) |-> m_axis_tlast)
        else $error("end marker not flagged as last of word");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && end_step) |=> (r_mode == MODE_A0 && r_esc == 5'd0))
        else $error("shift state not cleared after end marker");

endmodule
